[sv/ttl_pkg.sv]
// shared constants, types and row layout for the ternary truth-table lookup unit
package ttl_pkg;

  localparam int TABLE_ROWS  = 64;
  localparam int MAX_INPUTS  = 16;
  localparam int GATE_COUNT  = 8;
  localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap naturally

  localparam int GATE_W    = 3;
  localparam int PAT_W     = 16;
  localparam int SYM_W     = 8;
  localparam int ROW_AW    = $clog2(TABLE_ROWS);
  localparam int FILL_W    = ROW_AW + 1;
  localparam int Q_AW      = $clog2(QUEUE_DEPTH);
  localparam int Q_CW      = $clog2(QUEUE_DEPTH + 1);

  // positions at or above max_inputs never take part in a match
  localparam logic [PAT_W-1:0] INPUT_MASK =
    (MAX_INPUTS >= PAT_W) ? {PAT_W{1'b1}} : PAT_W'((17'd1 << MAX_INPUTS) - 17'd1);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_LOOKUP,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [GATE_W-1:0] gate;
    logic [PAT_W-1:0]  pattern;
    logic [PAT_W-1:0]  care;
    logic [SYM_W-1:0]  symbol;
  } cmd_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate;
    logic [PAT_W-1:0]  pattern;
    logic [PAT_W-1:0]  care;
    logic [SYM_W-1:0]  symbol;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic              scanning;
    logic [FILL_W-1:0] fill;
  } back_stat_t;

endpackage

[sv/ternary_truth_table_lookup_unit.sv]
// top level of the ternary truth-table lookup unit
// ternary truth-table lookup for gate-level simulation
// input channel: one beat per item; in_tuser[0] is the op (0 load a row, 1 look up);
//   in_tdata carries gate index, pattern bits, care mask and output symbol
// result channel: exactly one beat per input item, in order; out_tdata[0] is hit,
//   out_tdata[8:1] the symbol of the newest matching row (0 on a miss or a load)
// a load appends a row at the fill count; once all 64 rows are used, loads are
//   refused with hit 0; a lookup compares the newest row first, one row a cycle
// path: each beat is held in the front register, then in the command queue, and
//   its result in the result register; a lookup that scans k rows, k up to 64,
//   also waits on those reads, which go one by one through the single read port of the row memory
// throughput: one load per cycle when results are taken; lookups one at a time
// a front register and a two-deep command queue keep accepting beats while a
//   scan runs or a result waits; when the receiver stalls, the result beat holds
//   and the queue and the front register fill, after which in_tready drops
// reset (rst_n low, synchronous) empties the queue and the table, fill count zero
module ternary_truth_table_lookup_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // gate_index[2:0], pattern_bits[18:3], care_mask[34:19],
                                  // out_symbol[42:35], zero fill[47:43]
  input  logic [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // hit[0], result_symbol[8:1], zero fill[15:9]
);
  import ttl_pkg::*;

  // front to queue
  logic       push_valid, push_ready;
  cmd_t       push_cmd;
  // queue to back
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  // result beat
  logic             res_hit;
  logic [SYM_W-1:0] res_symbol;
  back_stat_t       stat;

  ttl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser[0]),
    .in_gate    (in_tdata[2:0]),
    .in_pattern (in_tdata[18:3]),
    .in_care    (in_tdata[34:19]),
    .in_symbol  (in_tdata[42:35]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ttl_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (cmd_valid),
    .rd_pop   (cmd_pop),
    .rd_cmd   (cmd)
  );

  ttl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_hit    (res_hit),
    .res_symbol (res_symbol),
    .stat       (stat)
  );

  assign out_tdata = {7'b0, res_symbol, res_hit};

`ifndef ASSERT_OFF
  // a scan only starts with the result slot free, and nothing else fills it
  a_scan_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scanning |-> !out_tvalid)
    else $error("result beat pending during a table scan");

  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= FILL_W'(TABLE_ROWS))
    else $error("fill count beyond table size");

  // rows are appended one at a time
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (stat.fill == $past(stat.fill)) || (stat.fill == $past(stat.fill) + 1'b1))
    else $error("fill count jumped");

  // a result without hit (a miss, a reject or a refused load) never carries a symbol
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[8:1] == '0))
    else $error("symbol on a result without hit");
`endif

endmodule

[sv/ttl_ram.sv]
// generic single-write, single-read ram with registered read data
module ttl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/ttl_front.sv]
// front stage: accepts input beats, classifies them and masks unused inputs
module ttl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [ttl_pkg::GATE_W-1:0] in_gate,
  input  logic [ttl_pkg::PAT_W-1:0]  in_pattern,
  input  logic [ttl_pkg::PAT_W-1:0]  in_care,
  input  logic [ttl_pkg::SYM_W-1:0]  in_symbol,
  output logic                  push_valid,
  input  logic                  push_ready,
  output ttl_pkg::cmd_t         push_cmd
);
  import ttl_pkg::*;

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic gate_ok;
  logic take;

  assign gate_ok  = int'(in_gate) < GATE_COUNT;
  assign in_ready = !valid_r || push_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (take) begin
      valid_nxt       = 1'b1;
      cmd_nxt.gate    = in_gate;
      cmd_nxt.pattern = in_pattern & INPUT_MASK;
      cmd_nxt.care    = in_care & INPUT_MASK;
      cmd_nxt.symbol  = in_symbol;
      if (!gate_ok) begin
        cmd_nxt.kind = CMD_REJECT;
      end else if (op_t'(in_op) == OP_LOAD) begin
        cmd_nxt.kind = CMD_LOAD;
      end else begin
        cmd_nxt.kind = CMD_LOOKUP;
      end
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign push_valid = valid_r;
  assign push_cmd   = cmd_r;

endmodule

[sv/ttl_fifo.sv]
// short command queue between front and back
module ttl_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ttl_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_pop,
  output ttl_pkg::cmd_t rd_cmd
);
  import ttl_pkg::*;

  cmd_t            slot_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            push, pop;

  assign wr_ready = count_r != Q_CW'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[sv/ttl_back.sv]
// back stage: writes rows, scans the table newest first, holds the result beat
module ttl_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  input  ttl_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       res_hit,
  output logic [ttl_pkg::SYM_W-1:0]  res_symbol,
  output ttl_pkg::back_stat_t        stat
);
  import ttl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ROW_AW-1:0] chk_addr_r, chk_addr_nxt;
  logic [GATE_W-1:0] gate_r, gate_nxt;
  logic [PAT_W-1:0]  key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;

  logic              slot_free;
  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_raddr;
  row_t              wr_row, rd_row;
  logic [ROW_W-1:0]  rd_bits;
  logic              row_match;
  logic              table_full;

  assign slot_free  = !out_valid_r || res_ready;
  assign cmd_pop    = (state_r == ST_IDLE) && cmd_valid && slot_free;
  assign table_full = fill_r >= FILL_W'(TABLE_ROWS);

  assign wr_row.gate    = cmd.gate;
  assign wr_row.pattern = cmd.pattern;
  assign wr_row.care    = cmd.care;
  assign wr_row.symbol  = cmd.symbol;

  assign rd_row    = row_t'(rd_bits);
  assign row_match = (rd_row.gate == gate_r) &&
                     (((rd_row.pattern ^ key_r) & rd_row.care) == '0);

  ttl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_ROWS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (fill_r[ROW_AW-1:0]),
    .wr_data (ROW_W'(wr_row)),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd_bits)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    chk_addr_nxt  = chk_addr_r;
    gate_nxt      = gate_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_hit_nxt   = out_hit_r;
    out_sym_nxt   = out_sym_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = chk_addr_r - 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.kind)
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = !table_full;
              out_sym_nxt   = '0;
              if (!table_full) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            CMD_LOOKUP: begin
              gate_nxt = cmd.gate;
              key_nxt  = cmd.pattern;
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                out_hit_nxt   = 1'b0;
                out_sym_nxt   = '0;
              end else begin
                // newest row first
                ram_re       = 1'b1;
                ram_raddr    = ROW_AW'(fill_r - 1'b1);
                chk_addr_nxt = ROW_AW'(fill_r - 1'b1);
                state_nxt    = ST_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = 1'b0;
              out_sym_nxt   = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // check the row read last cycle, fetch the next older one
        if (row_match) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b1;
          out_sym_nxt   = rd_row.symbol;
          state_nxt     = ST_IDLE;
        end else if (chk_addr_r == '0) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_sym_nxt   = '0;
          state_nxt     = ST_IDLE;
        end else begin
          ram_re       = 1'b1;
          chk_addr_nxt = chk_addr_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_addr_r <= chk_addr_nxt;
    gate_r     <= gate_nxt;
    key_r      <= key_nxt;
    out_hit_r  <= out_hit_nxt;
    out_sym_r  <= out_sym_nxt;
  end

  assign res_valid     = out_valid_r;
  assign res_hit       = out_hit_r;
  assign res_symbol    = out_sym_r;
  assign stat.scanning = state_r == ST_SCAN;
  assign stat.fill     = fill_r;

endmodule
